// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Default screen geometry
   localparam int DEFAULT_COLUMNS = 80;
   localparam int DEFAULT_ROWS    = 25;

   // Field widths of the channels
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int ADDR_W   = 11;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = ATTR_W + CHAR_W;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

   // Character codes and attributes
   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
   localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
   localparam logic [ATTR_W-1:0] RESET_ATTR     = 8'h0F;

   // Controller to datapath
   typedef struct packed {
      logic latch_req;    // capture the request fields, rewind the sweep pointer
      logic init_step;    // power-on blank of one cell
      logic clear_step;   // clear-screen blank of one cell
      logic exec_put;     // write the character and move the cursor
      logic home;         // cursor to row 0, column 0
      logic read_issue;   // read the addressed cell
      logic scroll_step;  // one step of the scroll sweep
      logic load_rsp;     // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                scroll_needed;
      logic                sweep_last;
   } status_type;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine: sequences put, clear, read, scroll and the power-on blank.
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tcw_pkg::status_type  status,
   output tcw_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_CLEAR  = 3'd3;
   localparam logic [2:0] S_SCROLL = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (status.op)
               tcw_pkg::OP_PUT: begin
                  cmd.exec_put = 1'b1;
                  state_in     = status.scroll_needed ? S_SCROLL : S_DONE;
               end
               tcw_pkg::OP_CLEAR: begin
                  cmd.home = 1'b1;
                  state_in = S_CLEAR;
               end
               tcw_pkg::OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) state_in = S_DONE;
         end
         S_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.sweep_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last pending scroll write lands this cycle
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/tcw_dp.sv =====
// Datapath: cursor, attribute, sweep pointer, screen store and result register.
`timescale 1ns / 1ps

module tcw_dp #(
   parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_text_attribute,
   input  logic [tcw_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]    req_cell_address,
   input  tcw_pkg::cmd_type              cmd,
   output tcw_pkg::status_type           status,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_read_cell
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int WIDE  = (AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W;

   localparam logic [CW-1:0]   COL_LAST  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0]   ROW_LAST  = RW'(ROWS - 1);
   localparam logic [AW-1:0]   COLS_A    = AW'(COLUMNS);
   localparam logic [AW-1:0]   PTR_LAST  = AW'(CELLS - 1);
   localparam logic [AW-1:0]   COPY_END  = AW'(CELLS - COLUMNS);
   localparam logic [WIDE-1:0] CELLS_W   = WIDE'(CELLS);

   // control registers
   logic [CW-1:0]                 col_ff, col_in;
   logic [RW-1:0]                 row_ff, row_in;
   logic [tcw_pkg::ATTR_W-1:0]    attr_ff;
   logic [AW-1:0]                 ptr_ff;
   logic                          pend_valid_ff;

   // payload registers
   logic [tcw_pkg::OPCODE_W-1:0]  op_ff;
   logic [tcw_pkg::CHAR_W-1:0]    char_ff;
   logic [tcw_pkg::ADDR_W-1:0]    addr_ff;
   logic [AW-1:0]                 pend_addr_ff;
   logic                          pend_copy_ff;
   logic [tcw_pkg::COL_W-1:0]     rsp_col_ff;
   logic [tcw_pkg::ROW_W-1:0]     rsp_row_ff;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell_ff;

   logic [AW-1:0]                 cur_idx;
   logic                          col_at_end, row_at_end;
   logic                          put_we, scroll_need;
   logic [AW-1:0]                 put_addr;
   logic [tcw_pkg::CHAR_W-1:0]    put_char;
   logic                          copy_phase;
   logic [WIDE-1:0]               addr_wide;
   logic                          addr_in_range;

   logic                          ram_we, ram_re;
   logic [AW-1:0]                 ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;

   assign cur_idx       = AW'(row_ff) * COLS_A + AW'(col_ff);
   assign col_at_end    = (col_ff == COL_LAST);
   assign row_at_end    = (row_ff == ROW_LAST);
   assign copy_phase    = (ptr_ff < COPY_END);
   assign addr_wide     = WIDE'(addr_ff);
   assign addr_in_range = (addr_wide < CELLS_W);

   // put: newline, backspace or an ordinary byte
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      put_we      = 1'b0;
      put_addr    = cur_idx;
      put_char    = char_ff;
      scroll_need = 1'b0;
      if (char_ff == tcw_pkg::NEWLINE_CHAR) begin
         col_in = '0;
         if (row_at_end) scroll_need = 1'b1;
         else            row_in      = row_ff + 1'b1;
      end else if (char_ff == tcw_pkg::BACKSPACE_CHAR) begin
         if (col_ff != '0) begin
            col_in   = col_ff - 1'b1;
            put_we   = 1'b1;
            put_addr = cur_idx - 1'b1;
            put_char = tcw_pkg::BLANK_CHAR;
         end
      end else begin
         put_we = 1'b1;
         if (col_at_end) begin
            col_in = '0;
            if (row_at_end) scroll_need = 1'b1;
            else            row_in      = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // write port: sweeps, put, then the delayed scroll write
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff;
      ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
      if (cmd.init_step) begin
         ram_we = 1'b1;
      end else if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_wdata = {attr_ff, tcw_pkg::BLANK_CHAR};
      end else if (cmd.exec_put && put_we) begin
         ram_we    = 1'b1;
         ram_waddr = put_addr;
         ram_wdata = {attr_ff, put_char};
      end else if (pend_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = pend_copy_ff ? ram_rdata : {attr_ff, tcw_pkg::BLANK_CHAR};
      end
   end

   assign ram_re    = (cmd.scroll_step && copy_phase) || cmd.read_issue;
   assign ram_raddr = cmd.scroll_step ? (ptr_ff + COLS_A) : AW'(addr_wide);

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         attr_ff       <= tcw_pkg::RESET_ATTR;
         ptr_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) attr_ff <= csr_text_attribute;
         if (cmd.exec_put) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end else if (cmd.home) begin
            col_ff <= '0;
            row_ff <= '0;
         end
         if (cmd.latch_req) begin
            ptr_ff <= '0;
         end else if (cmd.init_step || cmd.clear_step || cmd.scroll_step) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
         pend_valid_ff <= cmd.scroll_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code;
         addr_ff <= req_cell_address;
      end
      if (cmd.scroll_step) begin
         pend_addr_ff <= ptr_ff;
         pend_copy_ff <= copy_phase;
      end
      if (cmd.load_rsp) begin
         rsp_col_ff  <= tcw_pkg::COL_W'(col_ff);
         rsp_row_ff  <= tcw_pkg::ROW_W'(row_ff);
         rsp_cell_ff <= (op_ff == tcw_pkg::OP_READ && addr_in_range) ? ram_rdata : '0;
      end
   end

   assign status.op            = op_ff;
   assign status.scroll_needed = scroll_need;
   assign status.sweep_last    = (ptr_ff == PTR_LAST);

   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_read_cell  = rsp_cell_ff;

endmodule

// ===== hw/rtl/text_console_writer_top.sv =====
// Top level of the text console writer: controller, datapath and checks.
//
// Usage: a text-mode console holding COLUMNS x ROWS cells of 16 bits (attribute byte
// above character byte) plus a cursor. Each req item carries an opcode (put, clear,
// read, no-op), a character and a cell address; each item yields exactly one rsp item
// with the cursor after the operation and, for read, the addressed cell (else zero).
// The csr channel writes the attribute byte used by put, scroll and clear; it is
// always ready; the user must see that it is only written while no item is in flight;
// the block itself does not enforce this. From req accept to rsp valid an item passes
// the execute state and then the done state, which loads the result register; a
// put that scrolls first sweeps every cell (one cell per cycle through the single
// write port of the screen store) and drains the last write, and clear first
// sweeps every cell. One item is worked at a time: req_ready returns in the cycle
// after the result register loads.
// Reset: the cursor homes, the attribute returns to 0x0F, and a blanking pass writes
// every cell to a space with attribute 0x0F, with req_ready low throughout; csr
// writes are still taken.
// Stalls: a finished result waits in the output register while the next item is
// accepted and worked; that item then holds in its final state until rsp frees.
`timescale 1ns / 1ps

module text_console_writer_top #(
   parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_text_attribute,
   // request items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcw_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]    req_cell_address,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_read_cell
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   // attribute register takes a write on any cycle
   assign csr_ready = 1'b1;

   // sequence each item: accept, execute, sweep if needed, hand off the result
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the cursor, attribute, screen store and the result register
   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_text_attribute (csr_text_attribute),
      .req_opcode         (req_opcode),
      .req_char_code      (req_char_code),
      .req_cell_address   (req_cell_address),
      .cmd                (cmd),
      .status             (status),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_read_cell      (rsp_read_cell)
   );

   // an accepted item blocks the next one until its work is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // no item enters while a sweep owns the screen store
   assert property (@(posedge clock) disable iff (reset)
      (cmd.init_step || cmd.clear_step || cmd.scroll_step) |-> !req_ready)
      else $error("request ready during a sweep");

   // the reported cursor column always lies on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_cursor_col) < COLUMNS))
      else $error("cursor column off screen");

   // at most one of the sweep and put commands asks for the screen write port per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_step, cmd.clear_step, cmd.exec_put, cmd.scroll_step}))
      else $error("write port conflict");

endmodule

// ===== test/text_console_writer_top_test.sv =====
// Self-checking testbench for the text console writer: directed table, then random traffic.
`timescale 1ns / 1ps

module text_console_writer_top_test;
   import tcw_pkg::*;

   localparam int SCREEN_COLS  = DEFAULT_COLUMNS;
   localparam int SCREEN_ROWS  = DEFAULT_ROWS;
   localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
   // Worst case is every item scrolling through the whole screen plus both stalls;
   // take that several times over, including the blanking pass after reset.
   localparam int TIMEOUT_NS   = 25_000_000;
   localparam int PHASE_ITEMS  = 220;
   localparam int PHASES       = 5;

   // Cursor and cell returned by one item.
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] cell_val;
   } console_status_type;

   // One row of the directed table. A pinned row carries a hand-written status
   // that applies to its last repetition; the others rely on the predictor.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [CHAR_W-1:0]   ch;
      logic [ADDR_W-1:0]   addr;
      logic [6:0]          reps;
      logic                pinned;
      console_status_type  status;
   } stim_row_type;

   localparam int DIR_ROWS = 25;

   stim_row_type dir_table [DIR_ROWS] = '{
      // fresh screen after the blanking pass
      '{OP_READ,  8'h00,          11'd0,    7'd1,  1'b1, '{7'd0, 5'd0, 16'h0F20}},
      '{OP_READ,  8'h00,          11'd1999, 7'd1,  1'b1, '{7'd0, 5'd0, 16'h0F20}},
      // addresses past the screen read as zero
      '{OP_READ,  8'h00,          11'd2000, 7'd1,  1'b1, '{7'd0, 5'd0, 16'h0000}},
      '{OP_READ,  8'hFF,          11'h7FF,  7'd1,  1'b1, '{7'd0, 5'd0, 16'h0000}},
      // unused opcode leaves everything alone
      '{OP_NOP,   8'hFF,          11'h7FF,  7'd1,  1'b1, '{7'd0, 5'd0, 16'h0000}},
      // backspace at the home position does nothing
      '{OP_PUT,   BACKSPACE_CHAR, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd0, 16'h0000}},
      '{OP_PUT,   8'h41,          11'h7FF,  7'd1,  1'b1, '{7'd1, 5'd0, 16'h0000}},
      '{OP_PUT,   8'hFF,          11'd0,    7'd1,  1'b1, '{7'd2, 5'd0, 16'h0000}},
      '{OP_PUT,   8'h00,          11'd0,    7'd1,  1'b1, '{7'd3, 5'd0, 16'h0000}},
      '{OP_READ,  8'h00,          11'd0,    7'd1,  1'b1, '{7'd3, 5'd0, 16'h0F41}},
      '{OP_READ,  8'h00,          11'd1,    7'd1,  1'b1, '{7'd3, 5'd0, 16'h0FFF}},
      // backspace above column zero blanks the cell it steps onto
      '{OP_PUT,   BACKSPACE_CHAR, 11'd0,    7'd1,  1'b1, '{7'd2, 5'd0, 16'h0000}},
      '{OP_READ,  8'h00,          11'd2,    7'd1,  1'b0, '0},
      // high character codes are plain bytes
      '{OP_PUT,   8'h80,          11'd0,    7'd1,  1'b0, '0},
      '{OP_READ,  8'h00,          11'd2,    7'd1,  1'b0, '0},
      '{OP_PUT,   NEWLINE_CHAR,   11'd0,    7'd1,  1'b1, '{7'd0, 5'd1, 16'h0000}},
      '{OP_PUT,   BACKSPACE_CHAR, 11'd0,    7'd1,  1'b1, '{7'd0, 5'd1, 16'h0000}},
      // a full line wraps to the next row
      '{OP_PUT,   8'h57,          11'd0,    7'd80, 1'b1, '{7'd0, 5'd2, 16'h0000}},
      '{OP_READ,  8'h00,          11'd80,   7'd1,  1'b0, '0},
      // newlines run past the last row and scroll
      '{OP_PUT,   NEWLINE_CHAR,   11'd0,    7'd23, 1'b0, '0},
      '{OP_READ,  8'h00,          11'd0,    7'd1,  1'b0, '0},
      '{OP_READ,  8'h00,          11'd1920, 7'd1,  1'b0, '0},
      // a wrap on the bottom row scrolls too
      '{OP_PUT,   8'h7E,          11'd0,    7'd80, 1'b0, '0},
      '{OP_CLEAR, 8'h00,          11'd0,    7'd1,  1'b1, '{7'd0, 5'd0, 16'h0000}},
      '{OP_READ,  8'h00,          11'd1999, 7'd1,  1'b1, '{7'd0, 5'd0, 16'h0F20}}
   };

   // Block ports; every input starts at a known value.
   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                csr_valid          = 1'b0;
   logic                csr_ready;
   logic [ATTR_W-1:0]   csr_text_attribute = '0;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode         = OP_NOP;
   logic [CHAR_W-1:0]   req_char_code      = '0;
   logic [ADDR_W-1:0]   req_cell_address   = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic [CELL_W-1:0]   rsp_read_cell;

   // Hand-written status travelling alongside the item on the request port.
   logic                pin_en             = 1'b0;
   console_status_type  pin_status         = '0;

   // Predictor state: a private copy of the screen, cursor and attribute.
   logic [CELL_W-1:0]   screen_copy [SCREEN_CELLS];
   int                  col_copy;
   int                  row_copy;
   logic [ATTR_W-1:0]   attr_copy;

   // Status of every accepted item whose result has not come back yet, oldest first.
   console_status_type  cursor_cell_queue [$];

   int                  error_count = 0;
   bit                  idle_on     = 1'b1;
   int                  stall_left  = 0;

   text_console_writer_top #(
      .COLUMNS (SCREEN_COLS),
      .ROWS    (SCREEN_ROWS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_char_code      (req_char_code),
      .req_cell_address   (req_cell_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_read_cell      (rsp_read_cell)
   );

   // 2 ns period: high for one ns, low for one ns.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cell under the cursor, pinned to the last cell if the cursor is off the screen.
   function automatic int cursor_cell();
      int idx;
      idx = row_copy * SCREEN_COLS + col_copy;
      return (idx < SCREEN_CELLS) ? idx : SCREEN_CELLS - 1;
   endfunction

   // Advance the predictor by one item and return the status it should produce.
   function automatic console_status_type apply_console_op(logic [OPCODE_W-1:0] op,
                                                           logic [CHAR_W-1:0] ch,
                                                           logic [ADDR_W-1:0] addr);
      console_status_type r;
      int i;
      r.cell_val = '0;
      case (op)
         OP_PUT: begin
            if (ch == NEWLINE_CHAR) begin
               col_copy = 0;
               row_copy++;
            end else if (ch == BACKSPACE_CHAR) begin
               if (col_copy > 0) begin
                  col_copy--;
                  screen_copy[cursor_cell()] = {attr_copy, BLANK_CHAR};
               end
            end else begin
               screen_copy[cursor_cell()] = {attr_copy, ch};
               col_copy++;
            end
            // wrap at the end of a line
            if (col_copy >= SCREEN_COLS) begin
               col_copy = 0;
               row_copy++;
            end
            // past the last row: shift everything up, blank the bottom row
            if (row_copy >= SCREEN_ROWS) begin
               for (i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
                  screen_copy[i] = screen_copy[i + SCREEN_COLS];
               for (i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
                  screen_copy[i] = {attr_copy, BLANK_CHAR};
               row_copy = SCREEN_ROWS - 1;
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < SCREEN_CELLS; i++)
               screen_copy[i] = {attr_copy, BLANK_CHAR};
            col_copy = 0;
            row_copy = 0;
         end
         OP_READ: begin
            if (addr < SCREEN_CELLS)
               r.cell_val = screen_copy[addr];
         end
         default: ;
      endcase
      r.col = col_copy[COL_W-1:0];
      r.row = row_copy[ROW_W-1:0];
      return r;
   endfunction

   // Watch both channels at the rising edge: predict each accepted item and
   // compare each accepted result with the oldest pending status.
   always @(posedge clock) begin : watch
      console_status_type predicted;
      console_status_type want;
      int i;
      if (reset) begin
         for (i = 0; i < SCREEN_CELLS; i++)
            screen_copy[i] = {RESET_ATTR, BLANK_CHAR};
         col_copy  = 0;
         row_copy  = 0;
         attr_copy = RESET_ATTR;
         cursor_cell_queue.delete();
      end else begin
         if (csr_valid && csr_ready)
            attr_copy = csr_text_attribute;
         if (req_valid && req_ready) begin
            predicted = apply_console_op(req_opcode, req_char_code, req_cell_address);
            // a pinned item is checked against its hand-written status instead
            cursor_cell_queue.push_back(pin_en ? pin_status : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (cursor_cell_queue.size() == 0) begin
               $error("result with no pending item: col %0d row %0d cell %h",
                      rsp_cursor_col, rsp_cursor_row, rsp_read_cell);
               error_count++;
            end else begin
               want = cursor_cell_queue.pop_front();
               if (rsp_cursor_col !== want.col) begin
                  $error("cursor_col: expected %0d, actual %0d", want.col, rsp_cursor_col);
                  error_count++;
               end
               if (rsp_cursor_row !== want.row) begin
                  $error("cursor_row: expected %0d, actual %0d", want.row, rsp_cursor_row);
                  error_count++;
               end
               if (rsp_read_cell !== want.cell_val) begin
                  $error("read_cell: expected %h, actual %h", want.cell_val, rsp_read_cell);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver back-pressure: drop ready in random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // Offer one item, possibly after a short idle burst, and hold it until accepted.
   task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr, input logic pin,
                           input console_status_type pin_val);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 4) == 0)
         gap = $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_char_code    <= ch;
      req_cell_address <= addr;
      pin_en           <= pin;
      pin_status       <= pin_val;
      do @(posedge clock); while (!req_ready);
   endtask

   // Draw one random item. Puts dominate and carry plenty of newlines so that
   // the cursor regularly reaches the bottom and scrolls; clears stay rare.
   task automatic send_random_op();
      int                  pick;
      int                  sub;
      logic [OPCODE_W-1:0] op;
      logic [CHAR_W-1:0]   ch;
      logic [ADDR_W-1:0]   addr;
      pick = $urandom_range(0, 199);
      ch   = CHAR_W'($urandom_range(0, 255));
      addr = ADDR_W'($urandom_range(0, 2047));
      if (pick < 140) begin
         op  = OP_PUT;
         sub = $urandom_range(0, 19);
         if (sub < 5)
            ch = NEWLINE_CHAR;
         else if (sub < 7)
            ch = BACKSPACE_CHAR;
      end else if (pick < 190) begin
         op  = OP_READ;
         sub = $urandom_range(0, 9);
         // mostly on-screen, often on the cursor row, sometimes anywhere
         if (sub < 5)
            addr = ADDR_W'($urandom_range(0, SCREEN_CELLS - 1));
         else if (sub < 8)
            addr = ADDR_W'(row_copy * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
      end else if (pick < 199) begin
         op = OP_NOP;
      end else begin
         op = OP_CLEAR;
      end
      send_req(op, ch, addr, 1'b0, '0);
   endtask

   // Drop valid and wait until every accepted item has its result back.
   task automatic drain_items();
      @(negedge clock);
      req_valid <= 1'b0;
      pin_en    <= 1'b0;
      while (cursor_cell_queue.size() != 0) @(posedge clock);
   endtask

   // Write the attribute register through its handshake.
   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Main sequence: reset, directed table, random phases, final verdict.
   initial begin : stimulus
      int r;
      int k;
      int phase;
      logic [ATTR_W-1:0] attr;

      // Hold reset, then release it on a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table at the reset attribute. The first item waits
      // out the blanking pass on its own, since req_ready stays low until then.
      for (r = 0; r < DIR_ROWS; r++)
         for (k = 0; k < dir_table[r].reps; k++)
            send_req(dir_table[r].op, dir_table[r].ch, dir_table[r].addr,
                     dir_table[r].pinned && (k == dir_table[r].reps - 1),
                     dir_table[r].status);
      drain_items();

      // Random phases, each under its own attribute: both extremes first,
      // then random values, and the last phase with no idling at all.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       attr = '0;
            1:       attr = '1;
            default: attr = ATTR_W'($urandom_range(0, 255));
         endcase
         idle_on = (phase != PHASES - 1);
         write_attribute(attr);
         repeat (PHASE_ITEMS) send_random_op();
         drain_items();
      end

      // Keep the clock running before the verdict to catch any stray result.
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("text_console_writer_top_test passed");
      else
         $display("text_console_writer_top_test failed");
      $finish;
   end

   // Stop a hung run.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("text_console_writer_top_test failed");
      $finish;
   end

endmodule
